>>> design/mec_pkg.sv
`timescale 1ns / 1ps

package mec_pkg;

  // Default sizes.
  localparam int COORD_BITS_DEF = 12;
  localparam int ITER_BITS_DEF  = 24;
  localparam int FRAC_BITS_DEF  = 24;

  // Register widths and the configuration port.
  localparam int REG_W     = 32;
  localparam int CFG_IDX_W = 3;

  // Datapath: 64-bit signed words, magnitudes held in 62 bits.
  localparam int WORD_W = 64;
  localparam int MAG_W  = 62;
  localparam int HALF_W = 32;
  localparam int PROD_W = 2 * MAG_W;

  localparam logic signed [WORD_W:0] SAT_POS = 65'sh0_3FFF_FFFF_FFFF_FFFF;
  localparam logic signed [WORD_W:0] SAT_NEG = -SAT_POS;

  // Register reset values.
  localparam int unsigned        MAXIT_RESET  = 1000;
  localparam logic [REG_W-1:0]   ORIGIN_RESET = 32'hFE00_0000;
  localparam logic [REG_W-1:0]   STEP_RESET   = 32'h0000_4000;

  // Register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAX_ITER    = 3'd0,
    REG_ORIGIN_REAL = 3'd1,
    REG_ORIGIN_IMAG = 3'd2,
    REG_STEP_REAL   = 3'd3,
    REG_STEP_IMAG   = 3'd4
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_MUL,
    S_FIN,
    S_APPLY,
    S_CHECK
  } state_t;

  // Which product the shared multiplier is working on.
  typedef enum logic [2:0] {
    OP_CR,
    OP_CI,
    OP_XY,
    OP_XX,
    OP_YY
  } op_t;

  // Clamp a 65-bit sum to +-(2^62 - 1).
  function automatic logic signed [WORD_W-1:0] sat65(input logic signed [WORD_W:0] v);
    logic signed [WORD_W:0] r;
    if (v > SAT_POS) begin
      r = SAT_POS;
    end else if (v < SAT_NEG) begin
      r = SAT_NEG;
    end else begin
      r = v;
    end
    return r[WORD_W-1:0];
  endfunction

  // Sign-extend a word by one bit.
  function automatic logic signed [WORD_W:0] sx65(input logic signed [WORD_W-1:0] v);
    return $signed({v[WORD_W-1], v});
  endfunction

endpackage

>>> design/mandelbrot_escape_count.sv
`timescale 1ns / 1ps

// Mandelbrot escape-time counter. Each input transaction carries one pixel
// (column, row); the block forms c = (origin_real + column*step_real,
// origin_imag + row*step_imag) in signed fixed point with FRAC_BITS fraction
// bits, iterates z = z*z + c from zero with every sum and product clamped to
// +-(2^62 - 1), and returns one result transaction with the number of
// iterations run before |z|^2 >= 4 or before max_iterations is reached, plus
// the pixel indices. All multiplications go through one 32x32 unsigned
// multiplier: a 64-bit product takes four partial products, so each
// product runs operand load, four partials, finish and apply in turn.
// After each result the block goes back to idle before the next pixel is
// taken; the block takes one pixel at a time. The finished result sits
// in an output register and the block returns to idle while it waits
// there. Write the configuration registers only while the block is idle;
// index 0 is max_iterations, 1..2 origin real/imag, 3..4 step real/imag,
// and writes to other indexes are dropped.
module mandelbrot_escape_count
  import mec_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int ITER_BITS  = ITER_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration write port
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [REG_W-1:0]      cfg_data,
  // pixel input
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [COORD_BITS-1:0] in_column,
  input  logic [COORD_BITS-1:0] in_row,
  // result output
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [ITER_BITS-1:0]  out_escape_count,
  output logic [COORD_BITS-1:0] out_column,
  output logic [COORD_BITS-1:0] out_row
);

  // Escape threshold 4.0 in the fixed-point format.
  localparam logic signed [WORD_W-1:0] FOUR = WORD_W'(64'sd4 <<< FRAC_BITS);

  // Configuration registers.
  logic [ITER_BITS-1:0] maxit_r;
  logic [REG_W-1:0]     orig_re_r, orig_im_r, step_re_r, step_im_r;

  // Control.
  state_t state_r, state_nxt;
  op_t    op_r, op_nxt;
  logic [1:0] part_r;
  logic       out_valid_r;
  logic       done, emit;

  // Pixel and iteration state.
  logic [COORD_BITS-1:0]    col_r, row_r;
  logic signed [WORD_W-1:0] cr_r, ci_r, x_r, y_r, xs_r, ys_r, mag_r;
  logic [ITER_BITS-1:0]     count_r;

  // Shared multiplier datapath.
  logic [MAG_W-1:0]         ma_r, mb_r;
  logic                     neg_r;
  logic [PROD_W-1:0]        acc_r;
  logic signed [WORD_W-1:0] fm_r;

  logic signed [WORD_W-1:0] a_sel, b_sel, a_abs, b_abs;
  logic [HALF_W-1:0]        mul_a, mul_b;
  logic [2*HALF_W-1:0]      mul_p;
  logic [PROD_W-1:0]        addend, acc_nxt;
  logic [PROD_W-1:0]        shifted;
  logic [MAG_W-1:0]         m_mag;
  logic signed [WORD_W-1:0] y_nxt, x_nxt;

  // Output registers.
  logic [ITER_BITS-1:0]  escape_count_r;
  logic [COORD_BITS-1:0] out_column_r, out_row_r;

  assign in_ready         = (state_r == S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_escape_count = escape_count_r;
  assign out_column       = out_column_r;
  assign out_row          = out_row_r;

  // Stop once the limit is hit or the point has left the radius-2 disk.
  assign done = (count_r >= maxit_r) || (mag_r >= FOUR);
  // Hand off only when the output register is free or being drained.
  assign emit = (state_r == S_CHECK) && done && (!out_valid_r || out_ready);

  // Operand select for the product being started.
  always_comb begin
    a_sel = x_r;
    b_sel = y_r;
    case (op_r)
      OP_CR: begin
        a_sel = $signed(WORD_W'(col_r));
        b_sel = WORD_W'($signed(step_re_r));
      end
      OP_CI: begin
        a_sel = $signed(WORD_W'(row_r));
        b_sel = WORD_W'($signed(step_im_r));
      end
      OP_XY: begin
        a_sel = x_r;
        b_sel = y_r;
      end
      OP_XX: begin
        a_sel = x_r;
        b_sel = x_r;
      end
      OP_YY: begin
        a_sel = y_r;
        b_sel = y_r;
      end
      default: begin
        a_sel = x_r;
        b_sel = y_r;
      end
    endcase
    a_abs = a_sel[WORD_W-1] ? -a_sel : a_sel;
    b_abs = b_sel[WORD_W-1] ? -b_sel : b_sel;
  end

  // One partial product a cycle: low*low, low*high, high*low, high*high.
  always_comb begin
    mul_a  = part_r[1] ? HALF_W'(ma_r[MAG_W-1:HALF_W]) : ma_r[HALF_W-1:0];
    mul_b  = part_r[0] ? HALF_W'(mb_r[MAG_W-1:HALF_W]) : mb_r[HALF_W-1:0];
    mul_p  = mul_a * mul_b;
    addend = PROD_W'(mul_p);
    case (part_r)
      2'd0:    addend = PROD_W'(mul_p);
      2'd3:    addend = addend << (2 * HALF_W);
      default: addend = addend << HALF_W;
    endcase
    acc_nxt = ((part_r == 2'd0) ? '0 : acc_r) + addend;
  end

  // Finish: cut fraction bits toward zero and clamp, except for c products.
  always_comb begin
    shifted = acc_r >> FRAC_BITS;
    if (op_r == OP_CR || op_r == OP_CI) begin
      m_mag = acc_r[MAG_W-1:0];
    end else if (|shifted[PROD_W-1:MAG_W]) begin
      m_mag = '1;
    end else begin
      m_mag = shifted[MAG_W-1:0];
    end
  end

  // Iteration update from the x*y product and the previous squares.
  always_comb begin
    y_nxt = sat65(sx65(sat65($signed({fm_r, 1'b0}))) + sx65(ci_r));
    x_nxt = sat65(sx65(sat65(sx65(xs_r) - sx65(ys_r))) + sx65(cr_r));
  end

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt    = OP_CR;
          state_nxt = S_LOAD;
        end
      end
      S_LOAD:  state_nxt = S_MUL;
      S_MUL: begin
        if (part_r == 2'd3) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN:   state_nxt = S_APPLY;
      S_APPLY: begin
        unique case (op_r)
          OP_CR: begin
            op_nxt    = OP_CI;
            state_nxt = S_LOAD;
          end
          OP_CI:   state_nxt = S_CHECK;
          OP_XY: begin
            op_nxt    = OP_XX;
            state_nxt = S_LOAD;
          end
          OP_XX: begin
            op_nxt    = OP_YY;
            state_nxt = S_LOAD;
          end
          OP_YY:   state_nxt = S_CHECK;
          default: state_nxt = S_CHECK;
        endcase
      end
      S_CHECK: begin
        if (!done) begin
          op_nxt    = OP_XY;
          state_nxt = S_LOAD;
        end else if (emit) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      op_r    <= OP_CR;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
    end
  end

  // Configuration registers; mask to width, drop unknown indexes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      maxit_r   <= ITER_BITS'(MAXIT_RESET);
      orig_re_r <= ORIGIN_RESET;
      orig_im_r <= ORIGIN_RESET;
      step_re_r <= STEP_RESET;
      step_im_r <= STEP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MAX_ITER:    maxit_r   <= cfg_data[ITER_BITS-1:0];
        REG_ORIGIN_REAL: orig_re_r <= cfg_data;
        REG_ORIGIN_IMAG: orig_im_r <= cfg_data;
        REG_STEP_REAL:   step_re_r <= cfg_data;
        REG_STEP_IMAG:   step_im_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Result valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        // latch the pixel and clear the orbit
        col_r   <= in_column;
        row_r   <= in_row;
        x_r     <= '0;
        y_r     <= '0;
        xs_r    <= '0;
        ys_r    <= '0;
        mag_r   <= '0;
        count_r <= '0;
      end
      S_LOAD: begin
        ma_r   <= a_abs[MAG_W-1:0];
        mb_r   <= b_abs[MAG_W-1:0];
        neg_r  <= a_sel[WORD_W-1] ^ b_sel[WORD_W-1];
        part_r <= 2'd0;
      end
      S_MUL: begin
        acc_r  <= acc_nxt;
        part_r <= part_r + 2'd1;
      end
      S_FIN: begin
        fm_r <= neg_r ? -$signed(WORD_W'(m_mag)) : $signed(WORD_W'(m_mag));
      end
      S_APPLY: begin
        case (op_r)
          OP_CR: cr_r <= WORD_W'($signed(orig_re_r)) + fm_r;
          OP_CI: ci_r <= WORD_W'($signed(orig_im_r)) + fm_r;
          OP_XY: begin
            y_r <= y_nxt;
            x_r <= x_nxt;
          end
          OP_XX: xs_r <= fm_r;
          OP_YY: begin
            ys_r    <= fm_r;
            mag_r   <= sat65(sx65(xs_r) + sx65(fm_r));
            count_r <= count_r + 1'b1;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    if (emit) begin
      escape_count_r <= count_r;
      out_column_r   <= col_r;
      out_row_r      <= row_r;
    end
  end

endmodule

>>> dv/escape_count_checker.sv
`timescale 1ns / 1ps

module escape_count_checker
  import mec_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int ITER_BITS  = ITER_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [REG_W-1:0]      cfg_data,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [COORD_BITS-1:0] in_column,
  input  logic [COORD_BITS-1:0] in_row,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [ITER_BITS-1:0]  out_escape_count,
  input  logic [COORD_BITS-1:0] out_column,
  input  logic [COORD_BITS-1:0] out_row,
  output int                    error_count,
  output int                    pending_results
);

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic signed [WORD_W:0]   wide_t;

  typedef struct packed {
    logic [ITER_BITS-1:0]  count;
    logic [COORD_BITS-1:0] column;
    logic [COORD_BITS-1:0] row;
  } pixel_result_t;

  localparam word_t WORD_LIMIT = 64'sh3FFF_FFFF_FFFF_FFFF;

  // Shadow copy of the block's registers.
  logic [ITER_BITS-1:0]    iter_cap;
  logic signed [REG_W-1:0] re_origin;
  logic signed [REG_W-1:0] im_origin;
  logic signed [REG_W-1:0] re_step;
  logic signed [REG_W-1:0] im_step;

  pixel_result_t expected_pixels[$];
  int            failures;

  function automatic word_t clamp(input wide_t v);
    word_t r;
    if (v > wide_t'(WORD_LIMIT)) begin
      r = WORD_LIMIT;
    end else if (v < -wide_t'(WORD_LIMIT)) begin
      r = -WORD_LIMIT;
    end else begin
      r = v[WORD_W-1:0];
    end
    return r;
  endfunction

  // Fixed-point product: magnitude truncated, then clamped, then signed.
  function automatic word_t qmul(input word_t a, input word_t b);
    logic                neg;
    logic [WORD_W-1:0]   ua;
    logic [WORD_W-1:0]   ub;
    logic [2*WORD_W-1:0] prod;
    word_t               m;
    neg  = (a < 0) != (b < 0);
    ua   = (a < 0) ? -a : a;
    ub   = (b < 0) ? -b : b;
    prod = ({{WORD_W{1'b0}}, ua} * {{WORD_W{1'b0}}, ub}) >> FRAC_BITS;
    if (prod > {{WORD_W{1'b0}}, WORD_LIMIT}) begin
      m = WORD_LIMIT;
    end else begin
      m = prod[WORD_W-1:0];
    end
    return neg ? -m : m;
  endfunction

  function automatic logic [ITER_BITS-1:0] predict_escape_count(
    input logic [COORD_BITS-1:0] col,
    input logic [COORD_BITS-1:0] row
  );
    word_t       cr;
    word_t       ci;
    word_t       x;
    word_t       y;
    word_t       xs;
    word_t       ys;
    word_t       mag;
    word_t       four;
    int unsigned n;
    cr = clamp(wide_t'(re_origin) + wide_t'($signed({1'b0, col})) * wide_t'(re_step));
    ci = clamp(wide_t'(im_origin) + wide_t'($signed({1'b0, row})) * wide_t'(im_step));
    four = word_t'(4) <<< FRAC_BITS;
    x = 0;
    y = 0;
    xs = 0;
    ys = 0;
    mag = 0;
    n = 0;
    while (n < iter_cap && mag < four) begin
      y   = clamp(wide_t'(clamp(wide_t'(qmul(x, y)) * 2)) + wide_t'(ci));
      x   = clamp(wide_t'(clamp(wide_t'(xs) - wide_t'(ys))) + wide_t'(cr));
      xs  = qmul(x, x);
      ys  = qmul(y, y);
      mag = clamp(wide_t'(xs) + wide_t'(ys));
      n++;
    end
    return n[ITER_BITS-1:0];
  endfunction

  always @(posedge clk) begin
    pixel_result_t want;
    if (!rst_n) begin
      iter_cap   = ITER_BITS'(MAXIT_RESET);
      re_origin  = ORIGIN_RESET;
      im_origin  = ORIGIN_RESET;
      re_step    = STEP_RESET;
      im_step    = STEP_RESET;
      expected_pixels.delete();
      failures = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_MAX_ITER:    iter_cap   = cfg_data[ITER_BITS-1:0];
          REG_ORIGIN_REAL: re_origin  = cfg_data;
          REG_ORIGIN_IMAG: im_origin  = cfg_data;
          REG_STEP_REAL:   re_step    = cfg_data;
          REG_STEP_IMAG:   im_step    = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        expected_pixels.push_back({predict_escape_count(in_column, in_row), in_column, in_row});
      end
      if (out_valid && out_ready) begin
        if (expected_pixels.size() == 0) begin
          $display("%0t: unexpected result: count %0d pixel (%0d,%0d)",
                   $time, out_escape_count, out_column, out_row);
          failures++;
        end else begin
          want = expected_pixels.pop_front();
          if (out_escape_count !== want.count) begin
            $display("%0t: escape_count mismatch at (%0d,%0d): expected %0d, actual %0d",
                     $time, want.column, want.row, want.count, out_escape_count);
            failures++;
          end
          if (out_column !== want.column) begin
            $display("%0t: out_column mismatch: expected %0d, actual %0d",
                     $time, want.column, out_column);
            failures++;
          end
          if (out_row !== want.row) begin
            $display("%0t: out_row mismatch: expected %0d, actual %0d",
                     $time, want.row, out_row);
            failures++;
          end
        end
      end
    end
    error_count     <= failures;
    pending_results <= expected_pixels.size();
  end

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps

module tb
  import mec_pkg::*;
;

  // Random pixel budget; the last stretch of it runs with no idling.
  localparam int RANDOM_ITEMS     = 580;
  localparam int QUIET_ITEMS      = 80;
  localparam int LONG_HOLD_CYCLES = 400;
  // Slowest correct run: random pixels at most 60 iterations each plus
  // overhead, receiver stall and sender gap; two directed pixels run 1000
  // iterations each. Allow several times that.
  localparam int CYCLE_LIMIT      = 4_000_000;

  localparam logic [CFG_IDX_W-1:0] FIRST_UNMAPPED_REG = 3'd5;

  logic                      clk;
  logic                      rst_n;
  logic                      cfg_we;
  logic [CFG_IDX_W-1:0]      cfg_index;
  logic [REG_W-1:0]          cfg_data;
  logic                      in_valid;
  logic                      in_ready;
  logic [COORD_BITS_DEF-1:0] in_column;
  logic [COORD_BITS_DEF-1:0] in_row;
  logic                      out_valid;
  logic                      out_ready;
  logic [ITER_BITS_DEF-1:0]  out_escape_count;
  logic [COORD_BITS_DEF-1:0] out_column;
  logic [COORD_BITS_DEF-1:0] out_row;

  int error_count;
  int pending_results;

  // Set by the pixel source, read by the result sink.
  bit quiet_tail;
  bit long_hold_req;

  mandelbrot_escape_count dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_column        (in_column),
    .in_row           (in_row),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_escape_count (out_escape_count),
    .out_column       (out_column),
    .out_row          (out_row)
  );

  escape_count_checker chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_column        (in_column),
    .in_row           (in_row),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_escape_count (out_escape_count),
    .out_column       (out_column),
    .out_row          (out_row),
    .error_count      (error_count),
    .pending_results  (pending_results)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Present one pixel and hold it until the block takes the transaction.
  task automatic offer_pixel(input logic [COORD_BITS_DEF-1:0] col,
                             input logic [COORD_BITS_DEF-1:0] row);
    in_valid  <= 1'b1;
    in_column <= col;
    in_row    <= row;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drop valid for a random burst now and then.
  task automatic sender_gap();
    int n;
    if (!quiet_tail && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 18);
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Stop sending and wait until every predicted result has been seen.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
  endtask

  // Write all five registers back to back; junk goes into the bits above the
  // iteration limit so the width mask is exercised too. Optionally poke an
  // unmapped index last, which must leave every register alone.
  task automatic program_regs(input logic [ITER_BITS_DEF-1:0] lim,
                              input logic [REG_W-1:0] ore, input logic [REG_W-1:0] oim,
                              input logic [REG_W-1:0] sre, input logic [REG_W-1:0] sim,
                              input bit poke_unmapped);
    logic [REG_W-1:0] lim_word;
    lim_word = $urandom();
    lim_word[ITER_BITS_DEF-1:0] = lim;
    write_reg(REG_MAX_ITER, lim_word);
    write_reg(REG_ORIGIN_REAL, ore);
    write_reg(REG_ORIGIN_IMAG, oim);
    write_reg(REG_STEP_REAL, sre);
    write_reg(REG_STEP_IMAG, sim);
    if (poke_unmapped) begin
      write_reg(FIRST_UNMAPPED_REG + CFG_IDX_W'($urandom_range(0, 2)), $urandom());
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Watchdog: end the run if the block stops making progress.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("RESULT: ERROR");
    $finish;
  end

  // Result sink: random back-pressure bursts, plus one long hold-off on
  // request so the block backs up and stalls its input.
  initial begin
    bit long_hold_done;
    long_hold_done = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req && !long_hold_done) begin
        long_hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES - 1) @(posedge clk);
      end else if (!quiet_tail && $urandom_range(0, 11) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(0, 17)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Pixel source and configuration sequencing.
  initial begin
    int               sent;
    int               phase_no;
    int               style;
    int               n_items;
    int               i;
    logic [ITER_BITS_DEF-1:0] lim;
    logic [REG_W-1:0] ore;
    logic [REG_W-1:0] oim;
    logic [REG_W-1:0] sre;
    logic [REG_W-1:0] sim;

    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    in_valid      = 1'b0;
    in_column     = '0;
    in_row        = '0;
    quiet_tail    = 1'b0;
    long_hold_req = 1'b0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset view (-2..2 in both axes): the origin and a point on the real
    // axis stay inside and run the full 1000 iterations; the corners escape.
    offer_pixel(12'd2048, 12'd2048);
    offer_pixel(12'd1536, 12'd2048);
    offer_pixel(12'd0, 12'd0);
    offer_pixel(12'd4095, 12'd4095);
    drain();

    // Limit zero: no iteration at all, whatever the pixel.
    program_regs(24'd0, $urandom(), $urandom(), $urandom(), $urandom(), 1'b1);
    offer_pixel(12'd0, 12'd4095);
    offer_pixel(12'd4095, 12'd0);
    offer_pixel(12'd2048, 12'd2048);
    drain();

    // Largest limit with the largest positive origin and step: every point
    // lies far out and escapes after one iteration.
    program_regs(24'hFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
    offer_pixel(12'd4095, 12'd4095);
    offer_pixel(12'd0, 12'd0);
    offer_pixel(12'd1, 12'd2);
    drain();

    // Same with the most negative origin and step.
    program_regs(24'hFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1);
    offer_pixel(12'd4095, 12'd0);
    offer_pixel(12'd0, 12'd4095);
    offer_pixel(12'd4095, 12'd4095);
    drain();

    // Limit of one on the reset view: inside and outside points both stop at 1.
    program_regs(24'd1, ORIGIN_RESET, ORIGIN_RESET, STEP_RESET, STEP_RESET, 1'b0);
    offer_pixel(12'd2048, 12'd2048);
    offer_pixel(12'd0, 12'd0);
    drain();

    // Random phases, each with its own register setting.
    sent     = 0;
    phase_no = 0;
    while (sent < RANDOM_ITEMS) begin
      if (RANDOM_ITEMS - sent <= QUIET_ITEMS) begin
        quiet_tail = 1'b1;
      end
      style = $urandom_range(0, 9);
      if (phase_no == 2) begin
        // Cheap pixels so the long hold-off really backs the block up.
        lim = ITER_BITS_DEF'($urandom_range(1, 8));
        ore = $urandom();
        oim = $urandom();
        sre = $urandom();
        sim = $urandom();
      end else if (style < 6) begin
        // A window around the set, where counts spread over the whole range.
        lim = ITER_BITS_DEF'($urandom_range(0, 60));
        ore = -41943040 + $urandom_range(0, 50331648);
        oim = -25165824 + $urandom_range(0, 33554432);
        sre = $urandom_range(1024, 16384);
        sim = $urandom_range(1024, 16384);
        if ($urandom_range(0, 1) == 1) begin
          sre = -sre;
        end
        if ($urandom_range(0, 1) == 1) begin
          sim = -sim;
        end
      end else if (style < 8) begin
        lim = ITER_BITS_DEF'($urandom_range(0, 60));
        ore = $urandom();
        oim = $urandom();
        sre = $urandom();
        sim = $urandom();
      end else begin
        // Huge limit, but the real part is kept beyond +-64 so every pixel
        // escapes at once.
        lim = ITER_BITS_DEF'($urandom_range(24'h80_0000, 24'hFF_FFFF));
        oim = $urandom();
        sim = $urandom();
        if ($urandom_range(0, 1) == 1) begin
          ore = {2'b01, 30'($urandom())};
          sre = {2'b00, 30'($urandom())};
        end else begin
          ore = {2'b10, 30'($urandom())};
          sre = {2'b11, 30'($urandom())};
        end
      end
      program_regs(lim, ore, oim, sre, sim, $urandom_range(0, 3) == 0);

      n_items = $urandom_range(15, 45);
      if (n_items > RANDOM_ITEMS - sent) begin
        n_items = RANDOM_ITEMS - sent;
      end
      for (i = 0; i < n_items; i++) begin
        if (phase_no == 2 && i == 2) begin
          long_hold_req = 1'b1;
        end
        offer_pixel(COORD_BITS_DEF'($urandom_range(0, 4095)),
                    COORD_BITS_DEF'($urandom_range(0, 4095)));
        sent++;
        // Now and then pause the source until the block has emptied out.
        if (!quiet_tail && $urandom_range(0, 39) == 0) begin
          drain();
        end else begin
          sender_gap();
        end
      end
      drain();
      phase_no++;
    end

    // Let any stray late result surface before the verdict.
    repeat (64) @(posedge clk);
    if (error_count == 0 && pending_results == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
